[sv/mfba_pkg.sv]
// mfba_pkg: shared constants for the monochrome frame buffer access block
// no dependencies; imported by mono_frame_buffer_access_top
`default_nettype none

package mfba_pkg;

   // default store geometry
   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_HEIGHT_DEF = 256;

   // request field widths
   localparam int KIND_W  = 3;
   localparam int COORD_W = 16;
   localparam int BYTE_W  = 8;

   // configuration registers
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;
   localparam int WIDTH_W     = 10;
   localparam int HEIGHT_W    = 9;
   localparam int OFFSET_W    = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET = 2'd2;

   localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 10'd400;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 9'd240;
   localparam logic [OFFSET_W-1:0] OFFSET_RST = 10'd0;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_READ  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SET   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DRAW  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

   // erased pixel byte
   localparam logic [BYTE_W-1:0] BYTE_FILL = 8'hFF;

endpackage

`default_nettype wire

[sv/mfba_ram.sv]
// mfba_ram: generic single-write, single-read synchronous ram, registered read
// depends on nothing but the clock; used for the frame store
`default_nettype none

module mfba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  wire logic                                       clock,
   input  wire logic                                       write_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]                           write_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] read_addr,
   output logic      [WIDTH-1:0]                           read_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[write_addr] <= write_data;
      end
      read_data <= mem[read_addr];
   end

endmodule

`default_nettype wire

[sv/mono_frame_buffer_access_top.sv]
// mono_frame_buffer_access_top: one-bit-per-pixel frame store for a memory lcd
// depends on mfba_pkg and mfba_ram
`default_nettype none

// Usage
//  - request channel: drive req_kind, req_x, req_y, req_write_data and raise
//    start; the request is taken at a clock edge where start is high and busy
//    is low. busy stays high until the block can take the next request.
//  - kinds: read byte, write byte, set bit, draw pixel (y minus the row offset
//    register), clear (fill every byte with 0xff).
//  - response: rsp_strobe is high for exactly one cycle with rsp_read_data and
//    rsp_in_range; the receiver cannot stall, so the result is simply taken.
//  - sequence: busy stays high through decode, index with ram read, and
//    modify/write back; the strobe rises at the edge that ends modify/write
//    back, and a new pixel or byte request is taken only once busy is low,
//    through the single ram port pair.
//  - clear sweeps the store one byte per cycle over all
//    ROW_BYTES_MAX * MAX_HEIGHT bytes (16384 at the defaults) with busy high,
//    and the strobe rises at the edge that ends the sweep.
//  - reset runs the same sweep (16384 bytes at the defaults) with busy high
//    and no response; the configuration port is accepted during it.
//  - configuration: csr_valid / csr_ready with csr_index and csr_write_data;
//    csr_ready is always high. write only while no request is in flight.
module mono_frame_buffer_access_top #(
   parameter int MAX_WIDTH  = mfba_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = mfba_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [mfba_pkg::KIND_W-1:0]        req_kind,
   input  wire logic signed [mfba_pkg::COORD_W-1:0] req_x,
   input  wire logic signed [mfba_pkg::COORD_W-1:0] req_y,
   input  wire logic [mfba_pkg::BYTE_W-1:0]        req_write_data,
   // response channel
   output logic                                    rsp_strobe,
   output logic [mfba_pkg::BYTE_W-1:0]             rsp_read_data,
   output logic                                    rsp_in_range,
   // configuration port
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [mfba_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [mfba_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   import mfba_pkg::*;

   // store geometry
   localparam int ROW_BYTES_MAX = (MAX_WIDTH + 7) / 8;
   localparam int DEPTH   = ROW_BYTES_MAX * MAX_HEIGHT;
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int W_BITS  = $clog2(MAX_WIDTH + 1);
   localparam int H_BITS  = $clog2(MAX_HEIGHT + 1);
   localparam int RB_BITS = $clog2(ROW_BYTES_MAX + 1);
   localparam int YRB     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int XBB     = (ROW_BYTES_MAX > 1) ? $clog2(ROW_BYTES_MAX) : 1;
   localparam int CWW     = (W_BITS > WIDTH_W) ? W_BITS : WIDTH_W;
   localparam int CHW     = (H_BITS > HEIGHT_W) ? H_BITS : HEIGHT_W;
   localparam int YE_W    = COORD_W + 1;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ADDR  = 3'd1;
   localparam logic [2:0] ST_IDX   = 3'd2;
   localparam logic [2:0] ST_MOD   = 3'd3;
   localparam logic [2:0] ST_CLEAR = 3'd4;

   // configuration registers
   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [OFFSET_W-1:0] offset_ff;

   // control
   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] cursor_ff, cursor_in;
   logic          clr_rsp_ff, clr_rsp_in;

   // latched request
   logic [KIND_W-1:0]  kind_ff;
   logic [COORD_W-1:0] x_ff;
   logic [COORD_W-1:0] y_ff;
   logic [BYTE_W-1:0]  wdata_ff;

   // decoded access
   logic           ok_ff, ok_in;
   logic [YRB-1:0] yrow_ff;
   logic [XBB-1:0] xbyte_ff;
   logic [2:0]     bit_ff;
   logic [AW-1:0]  idx_ff, idx_in;

   // response registers
   logic              strobe_ff, strobe_in;
   logic [BYTE_W-1:0] rd_ff, rd_in;
   logic              inr_ff, inr_in;

   // ram
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [BYTE_W-1:0] ram_wdata;
   logic [BYTE_W-1:0] ram_rdata;

   // effective geometry
   logic [W_BITS-1:0]        eff_w;
   logic [H_BITS-1:0]        eff_h;
   logic [RB_BITS-1:0]       row_bytes;
   logic [W_BITS:0]          w_round;
   logic signed [YE_W-1:0]   y_eff;
   logic                     coord_ok;
   logic                     kind_pix;
   logic [YRB+RB_BITS-1:0]   row_base;
   logic [BYTE_W-1:0]        bit_mask;
   logic [BYTE_W-1:0]        byte_mod;
   logic                     accept;

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;

   // saturate panel size to the store geometry
   always_comb begin
      if (CWW'(width_ff) > CWW'(MAX_WIDTH)) begin
         eff_w = W_BITS'(MAX_WIDTH);
      end else begin
         eff_w = W_BITS'(width_ff);
      end
      if (CHW'(height_ff) > CHW'(MAX_HEIGHT)) begin
         eff_h = H_BITS'(MAX_HEIGHT);
      end else begin
         eff_h = H_BITS'(height_ff);
      end
   end

   // bytes per row, rounded up
   assign w_round   = {1'b0, eff_w} + (W_BITS + 1)'(7);
   assign row_bytes = RB_BITS'(w_round >> 3);

   // draw pixel shifts y by the line offset
   always_comb begin
      if (kind_ff == KIND_DRAW) begin
         y_eff = $signed({y_ff[COORD_W-1], y_ff})
               - YE_W'($signed(offset_ff));
      end else begin
         y_eff = $signed({y_ff[COORD_W-1], y_ff});
      end
   end

   assign kind_pix = (kind_ff == KIND_READ) || (kind_ff == KIND_WRITE)
                  || (kind_ff == KIND_SET) || (kind_ff == KIND_DRAW);

   // a nonnegative y_eff always fits in COORD_W bits
   assign coord_ok = !x_ff[COORD_W-1] && !y_eff[YE_W-1]
                  && (x_ff < COORD_W'(eff_w))
                  && (y_eff[COORD_W-1:0] < COORD_W'(eff_h));

   assign ok_in = kind_pix && coord_ok;

   // byte index of the decoded pixel
   assign row_base = YRB'(yrow_ff) * row_bytes;
   assign idx_in   = AW'(row_base) + AW'(xbyte_ff);

   // read-modify-write of one pixel
   assign bit_mask = BYTE_W'(1) << bit_ff;
   assign byte_mod = wdata_ff[0] ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      cursor_in  = cursor_ff;
      clr_rsp_in = clr_rsp_ff;
      strobe_in  = 1'b0;
      rd_in      = '0;
      inr_in     = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = idx_ff;
      ram_wdata  = wdata_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_CLEAR) begin
                  state_in   = ST_CLEAR;
                  cursor_in  = '0;
                  clr_rsp_in = 1'b1;
               end else begin
                  state_in = ST_ADDR;
               end
            end
         end
         ST_ADDR: begin
            state_in = ST_IDX;
         end
         ST_IDX: begin
            state_in = ST_MOD;
         end
         ST_MOD: begin
            state_in  = ST_IDLE;
            strobe_in = 1'b1;
            inr_in    = ok_ff;
            if (kind_ff == KIND_READ) begin
               rd_in = ok_ff ? ram_rdata : BYTE_FILL;
            end
            if (ok_ff && (kind_ff == KIND_WRITE)) begin
               ram_we = 1'b1;
            end
            if (ok_ff && ((kind_ff == KIND_SET) || (kind_ff == KIND_DRAW))) begin
               ram_we    = 1'b1;
               ram_wdata = byte_mod;
            end
         end
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = cursor_ff;
            ram_wdata = BYTE_FILL;
            cursor_in = cursor_ff + AW'(1);
            if (cursor_ff == AW'(DEPTH - 1)) begin
               state_in   = ST_IDLE;
               cursor_in  = '0;
               clr_rsp_in = 1'b0;
               strobe_in  = clr_rsp_ff;
               inr_in     = clr_rsp_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         cursor_ff  <= '0;
         clr_rsp_ff <= 1'b0;
         strobe_ff  <= 1'b0;
         width_ff   <= WIDTH_RST;
         height_ff  <= HEIGHT_RST;
         offset_ff  <= OFFSET_RST;
      end else begin
         state_ff   <= state_in;
         cursor_ff  <= cursor_in;
         clr_rsp_ff <= clr_rsp_in;
         strobe_ff  <= strobe_in;
         if (csr_valid && csr_ready) begin
            // unused index is ignored
            unique case (csr_index)
               CSR_WIDTH: begin
                  width_ff <= WIDTH_W'(csr_write_data);
               end
               CSR_HEIGHT: begin
                  height_ff <= HEIGHT_W'(csr_write_data);
               end
               CSR_OFFSET: begin
                  offset_ff <= OFFSET_W'(csr_write_data);
               end
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_kind;
         x_ff     <= req_x;
         y_ff     <= req_y;
         wdata_ff <= req_write_data;
      end
      if (state_ff == ST_ADDR) begin
         ok_ff    <= ok_in;
         yrow_ff  <= YRB'(y_eff);
         xbyte_ff <= XBB'(x_ff >> 3);
         bit_ff   <= x_ff[2:0];
      end
      if (state_ff == ST_IDX) begin
         idx_ff <= idx_in;
      end
      rd_ff  <= rd_in;
      inr_ff <= inr_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_read_data = rd_ff;
   assign rsp_in_range  = inr_ff;

   // frame store, read issued in the index cycle
   mfba_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock      (clock),
      .write_en   (ram_we),
      .write_addr (ram_waddr),
      .write_data (ram_wdata),
      .read_addr  (idx_in),
      .read_data  (ram_rdata)
   );

endmodule

`default_nettype wire
